FILE: rtl/assert_macros.svh
// Assertion macros shared by the controller, datapath and divider.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Condition in one cycle that implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/tpvi_pkg.sv
// Types and constants of the three-axis PID controller.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package tpvi_pkg;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ERR,
		OP_WSEL,
		OP_WWAIT,
		OP_MULW,
		OP_IDIV,
		OP_IWAIT,
		OP_INT,
		OP_MKDL,
		OP_MD,
		OP_MP,
		OP_MI,
		OP_ACC,
		OP_VEL,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic fade;
		logic div_done;
	} status_t;

	// Register indexes.
	localparam logic [2:0] REG_GAIN_P_XY = 3'd0;
	localparam logic [2:0] REG_GAIN_I_XY = 3'd1;
	localparam logic [2:0] REG_GAIN_D_XY = 3'd2;
	localparam logic [2:0] REG_GAIN_P_Z  = 3'd3;
	localparam logic [2:0] REG_GAIN_I_Z  = 3'd4;
	localparam logic [2:0] REG_GAIN_D_Z  = 3'd5;
	localparam logic [2:0] REG_BAND      = 3'd6;
	localparam logic [2:0] REG_BASE      = 3'd7;

	localparam logic [15:0] RST_GAIN_P_XY = 16'd3277;
	localparam logic [15:0] RST_GAIN_I_XY = 16'd819;
	localparam logic [15:0] RST_GAIN_D_XY = 16'd819;
	localparam logic [15:0] RST_GAIN_P_Z  = 16'd2867;
	localparam logic [15:0] RST_GAIN_I_Z  = 16'd410;
	localparam logic [15:0] RST_GAIN_D_Z  = 16'd819;
	localparam logic [30:0] RST_BAND      = 31'd65536;
	localparam logic [30:0] RST_BASE      = 31'd32768;

	localparam logic [1:0] AXIS_Z = 2'd2;

	// Integrator clamp (0.3), arrival limit (0.1) and velocity limit (0.5).
	localparam logic signed [15:0] I_LIMIT    = 16'sd19661;
	localparam logic [31:0]        ARRIVE_LIM = 32'd6554;
	localparam logic signed [16:0] V_LIMIT    = 17'sd32768;
	localparam logic [16:0]        W_FULL     = 17'd65536;

	// Divider width and step count.
	localparam int DIV_W = 48;

endpackage

`default_nettype wire

FILE: rtl/tpvi_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tpvi_pkg for the dividend width.
`default_nettype none

`include "assert_macros.svh"

module tpvi_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tpvi_pkg::DIV_W-1:0]   dividend,
	input  wire logic [31:0]                  divisor,
	output logic                              done,
	output logic [tpvi_pkg::DIV_W-1:0]        quotient
);

	localparam int CW = $clog2(tpvi_pkg::DIV_W + 1);

	logic [tpvi_pkg::DIV_W-1:0] dq_q;
	logic [31:0]                rem_q;
	logic [31:0]                div_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [32:0]                trial;
	logic                       ge;

	// One step: bring down the next dividend bit and try to subtract.
	always_comb begin
		trial = {rem_q, dq_q[tpvi_pkg::DIV_W-1]};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(tpvi_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Working registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			dq_q  <= {dq_q[tpvi_pkg::DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q && !done_q)
	`ASSERT_ALWAYS(a_done_idle, clk, arst_n, !(done_q && busy_q))

endmodule

`default_nettype wire

FILE: rtl/tpvi_ctrl.sv
// Controller: sequences the datapath through the three axes of one tick.
// Depends on tpvi_pkg for the command and status types.
`default_nettype none

`include "assert_macros.svh"

module tpvi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire tpvi_pkg::status_t status,
	output tpvi_pkg::cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_ERR, S_WSEL, S_WWAIT, S_MULW, S_IDIV, S_IWAIT, S_INT,
		S_MKDL, S_MD, S_MP, S_MI, S_ACC, S_VEL, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic       out_valid_q;
	logic       publish;

	assign publish = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Operation for the current state.
	always_comb begin
		cmd.axis = axis_q;
		case (state_q)
			S_IDLE:  cmd.op = in_valid ? tpvi_pkg::OP_LOAD : tpvi_pkg::OP_NONE;
			S_ERR:   cmd.op = tpvi_pkg::OP_ERR;
			S_WSEL:  cmd.op = tpvi_pkg::OP_WSEL;
			S_WWAIT: cmd.op = tpvi_pkg::OP_WWAIT;
			S_MULW:  cmd.op = tpvi_pkg::OP_MULW;
			S_IDIV:  cmd.op = tpvi_pkg::OP_IDIV;
			S_IWAIT: cmd.op = tpvi_pkg::OP_IWAIT;
			S_INT:   cmd.op = tpvi_pkg::OP_INT;
			S_MKDL:  cmd.op = tpvi_pkg::OP_MKDL;
			S_MD:    cmd.op = tpvi_pkg::OP_MD;
			S_MP:    cmd.op = tpvi_pkg::OP_MP;
			S_MI:    cmd.op = tpvi_pkg::OP_MI;
			S_ACC:   cmd.op = tpvi_pkg::OP_ACC;
			S_VEL:   cmd.op = tpvi_pkg::OP_VEL;
			S_DONE:  cmd.op = publish ? tpvi_pkg::OP_PUBLISH : tpvi_pkg::OP_NONE;
			default: cmd.op = tpvi_pkg::OP_NONE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					axis_q <= '0;
					if (in_valid)
						state_q <= S_ERR;
				end
				S_ERR:   state_q <= S_WSEL;
				S_WSEL:  state_q <= status.fade ? S_WWAIT : S_MULW;
				S_WWAIT: if (status.div_done) state_q <= S_MULW;
				S_MULW:  state_q <= S_IDIV;
				S_IDIV:  state_q <= S_IWAIT;
				S_IWAIT: state_q <= S_INT;
				S_INT:   state_q <= S_MKDL;
				S_MKDL:  state_q <= S_MD;
				S_MD:    state_q <= S_MP;
				S_MP:    state_q <= S_MI;
				S_MI:    state_q <= S_ACC;
				S_ACC:   state_q <= S_VEL;
				S_VEL: begin
					if (axis_q == tpvi_pkg::AXIS_Z) begin
						state_q <= S_DONE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_ERR;
					end
				end
				S_DONE:  if (publish) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_publish_valid, clk, arst_n, publish, out_valid_q && state_q == S_IDLE)

endmodule

`default_nettype wire

FILE: rtl/tpvi_datapath.sv
// Datapath: registers, error and weight logic, shared multiplier and divider.
// Depends on tpvi_pkg and tpvi_divider.
`default_nettype none

`include "assert_macros.svh"

module tpvi_datapath #(
	parameter int LOOP_RATE_HZ = 50
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tpvi_pkg::cmd_t           cmd,
	output tpvi_pkg::status_t             status,
	input  wire logic                     cfg_we,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [30:0]              cfg_data,
	input  wire logic                     restart,
	input  wire logic signed [31:0]       target_x,
	input  wire logic signed [31:0]       target_y,
	input  wire logic signed [31:0]       target_z,
	input  wire logic signed [31:0]       measured_x,
	input  wire logic signed [31:0]       measured_y,
	input  wire logic signed [31:0]       measured_z,
	output logic signed [16:0]            vel_x,
	output logic signed [16:0]            vel_y,
	output logic signed [16:0]            vel_z,
	output logic                          arrived
);

	localparam int DW = tpvi_pkg::DIV_W;

	// Division by the loop rate for a value below 2^31 is a multiplication by
	// the rounded-up reciprocal followed by a shift, exact over that range.
	localparam int          RATE_SH    = 31 + $clog2(LOOP_RATE_HZ);
	localparam logic [31:0] RATE_RECIP = 32'(((64'd1 << RATE_SH) +
		64'(LOOP_RATE_HZ) - 64'd1) / 64'(LOOP_RATE_HZ));

	// Configuration registers.
	logic [15:0] kp_xy_q, ki_xy_q, kd_xy_q, kp_z_q, ki_z_q, kd_z_q;
	logic [30:0] band_q, base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_xy_q <= tpvi_pkg::RST_GAIN_P_XY;
			ki_xy_q <= tpvi_pkg::RST_GAIN_I_XY;
			kd_xy_q <= tpvi_pkg::RST_GAIN_D_XY;
			kp_z_q  <= tpvi_pkg::RST_GAIN_P_Z;
			ki_z_q  <= tpvi_pkg::RST_GAIN_I_Z;
			kd_z_q  <= tpvi_pkg::RST_GAIN_D_Z;
			band_q  <= tpvi_pkg::RST_BAND;
			base_q  <= tpvi_pkg::RST_BASE;
		end else if (cfg_we) begin
			case (cfg_index)
				tpvi_pkg::REG_GAIN_P_XY: kp_xy_q <= cfg_data[15:0];
				tpvi_pkg::REG_GAIN_I_XY: ki_xy_q <= cfg_data[15:0];
				tpvi_pkg::REG_GAIN_D_XY: kd_xy_q <= cfg_data[15:0];
				tpvi_pkg::REG_GAIN_P_Z:  kp_z_q  <= cfg_data[15:0];
				tpvi_pkg::REG_GAIN_I_Z:  ki_z_q  <= cfg_data[15:0];
				tpvi_pkg::REG_GAIN_D_Z:  kd_z_q  <= cfg_data[15:0];
				tpvi_pkg::REG_BAND:      band_q  <= cfg_data;
				tpvi_pkg::REG_BASE:      base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Gains of the axis at work.
	logic        is_z;
	logic [15:0] kp, ki, kd;
	assign is_z = (cmd.axis == tpvi_pkg::AXIS_Z);
	assign kp   = is_z ? kp_z_q : kp_xy_q;
	assign ki   = is_z ? ki_z_q : ki_xy_q;
	assign kd   = is_z ? kd_z_q : kd_xy_q;

	// Captured tick.
	logic signed [31:0] tgt_q [3];
	logic signed [31:0] mea_q [3];

	always_ff @(posedge clk) begin
		if (cmd.op == tpvi_pkg::OP_LOAD) begin
			tgt_q[0] <= target_x;
			tgt_q[1] <= target_y;
			tgt_q[2] <= target_z;
			mea_q[0] <= measured_x;
			mea_q[1] <= measured_y;
			mea_q[2] <= measured_z;
		end
	end

	// Saturated error and its magnitude.
	logic signed [32:0] diff;
	logic signed [31:0] e_sat;
	logic [31:0]        ae_sat;
	logic signed [31:0] e_q;
	logic [31:0]        ae_q;

	always_comb begin
		diff = 33'(tgt_q[cmd.axis]) - 33'(mea_q[cmd.axis]);
		if (diff[32] != diff[31])
			e_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			e_sat = diff[31:0];
		ae_sat = e_sat[31] ? 32'(-{1'b1, e_sat}) : e_sat;
	end

	// Weight classification.
	logic [31:0] base_band;
	logic        w_full, w_zero, fade;
	logic [31:0] w_rem;
	assign base_band = {1'b0, base_q} + {1'b0, band_q};
	assign w_full    = ae_q <= {1'b0, base_q};
	assign w_zero    = (band_q == '0) || (ae_q >= base_band);
	assign fade      = !w_full && !w_zero;
	assign w_rem     = base_band - ae_q;

	// Divider for the weight inside the fade band.
	logic          div_start, div_done;
	logic [DW-1:0] div_dividend, div_quot;
	logic [31:0]   div_divisor;
	logic signed [60:0] prod_q;

	assign div_dividend = {1'b0, w_rem[30:0], 16'b0};
	assign div_divisor  = {1'b0, band_q};
	assign div_start    = (cmd.op == tpvi_pkg::OP_WSEL) && fade;

	tpvi_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign status.fade     = fade;
	assign status.div_done = div_done;

	// Shared multiplier operands.
	logic [16:0]        w_q;
	logic signed [32:0] de_q;
	logic signed [15:0] i_q;
	logic signed [33:0] mul_a;
	logic signed [26:0] mul_b;

	always_comb begin
		case (cmd.op)
			tpvi_pkg::OP_MULW: begin
				mul_a = $signed({2'b0, ae_q});
				mul_b = $signed({10'b0, w_q});
			end
			tpvi_pkg::OP_MKDL: begin
				mul_a = $signed({18'b0, kd});
				mul_b = 27'(LOOP_RATE_HZ);
			end
			tpvi_pkg::OP_MD: begin
				mul_a = 34'(de_q);
				mul_b = $signed({1'b0, prod_q[25:0]});
			end
			tpvi_pkg::OP_MP: begin
				mul_a = 34'(e_q);
				mul_b = $signed({11'b0, kp});
			end
			tpvi_pkg::OP_MI: begin
				mul_a = 34'(i_q);
				mul_b = $signed({11'b0, ki});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Integrator update and derivative difference.
	logic signed [15:0] integ_q [3];
	logic signed [31:0] prev_q  [3];
	logic [31:0]        inc_mag_q;
	logic [62:0]        rate_prod_q;
	logic signed [34:0] inc_s, i_sum;
	logic signed [15:0] i_new;
	logic signed [32:0] de_new;

	always_comb begin
		inc_s = e_q[31] ? -$signed({3'b0, inc_mag_q}) : $signed({3'b0, inc_mag_q});
		i_sum = 35'(integ_q[cmd.axis]) + inc_s;
		if (i_sum > 35'(tpvi_pkg::I_LIMIT))
			i_new = tpvi_pkg::I_LIMIT;
		else if (i_sum < -35'(tpvi_pkg::I_LIMIT))
			i_new = -tpvi_pkg::I_LIMIT;
		else
			i_new = i_sum[15:0];
		de_new = 33'(e_q) - 33'(prev_q[cmd.axis]);
	end

	// Velocity saturation and scaling.
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_ext;
	logic signed [63:0] acc_rnd;
	logic signed [16:0] vel_new;

	assign prod_ext = 64'(prod_q);

	always_comb begin
		acc_rnd = acc_q[63] ? acc_q + 64'sd4095 : acc_q;
		if (acc_q >= 64'sd134217728)
			vel_new = tpvi_pkg::V_LIMIT;
		else if (acc_q <= -64'sd134217728)
			vel_new = -tpvi_pkg::V_LIMIT;
		else
			vel_new = acc_rnd[28:12];
	end

	// State that reset and restart clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				integ_q[k] <= '0;
				prev_q[k]  <= '0;
			end
		end else if (cmd.op == tpvi_pkg::OP_LOAD && restart) begin
			for (int k = 0; k < 3; k++) begin
				integ_q[k] <= '0;
				prev_q[k]  <= '0;
			end
		end else if (cmd.op == tpvi_pkg::OP_INT) begin
			integ_q[cmd.axis] <= i_new;
			prev_q[cmd.axis]  <= e_q;
		end
	end

	// Working registers.
	logic signed [16:0] vel_w_q [3];
	logic               arr_q;
	logic signed [16:0] vel_x_q, vel_y_q, vel_z_q;
	logic               arrived_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			tpvi_pkg::OP_LOAD:  arr_q <= 1'b1;
			tpvi_pkg::OP_ERR: begin
				e_q  <= e_sat;
				ae_q <= ae_sat;
				if (!is_z && ae_sat >= tpvi_pkg::ARRIVE_LIM)
					arr_q <= 1'b0;
			end
			tpvi_pkg::OP_WSEL:  w_q <= w_full ? tpvi_pkg::W_FULL : '0;
			tpvi_pkg::OP_WWAIT: if (div_done) w_q <= div_quot[16:0];
			// Weighted error over 2^16, scaled by the loop-rate reciprocal.
			tpvi_pkg::OP_IDIV:  rate_prod_q <= {32'b0, prod_q[46:16]} * {31'b0, RATE_RECIP};
			tpvi_pkg::OP_IWAIT: inc_mag_q <= 32'(rate_prod_q >> RATE_SH);
			tpvi_pkg::OP_INT: begin
				i_q  <= i_new;
				de_q <= de_new;
			end
			tpvi_pkg::OP_MULW, tpvi_pkg::OP_MKDL, tpvi_pkg::OP_MD:
				prod_q <= mul_a * mul_b;
			tpvi_pkg::OP_MP: begin
				prod_q <= mul_a * mul_b;
				acc_q  <= prod_ext;
			end
			tpvi_pkg::OP_MI: begin
				prod_q <= mul_a * mul_b;
				acc_q  <= acc_q + prod_ext;
			end
			tpvi_pkg::OP_ACC:   acc_q <= acc_q + prod_ext;
			tpvi_pkg::OP_VEL:   vel_w_q[cmd.axis] <= vel_new;
			tpvi_pkg::OP_PUBLISH: begin
				vel_x_q   <= vel_w_q[0];
				vel_y_q   <= vel_w_q[1];
				vel_z_q   <= vel_w_q[2];
				arrived_q <= arr_q;
			end
			default: ;
		endcase
	end

	assign vel_x   = vel_x_q;
	assign vel_y   = vel_y_q;
	assign vel_z   = vel_z_q;
	assign arrived = arrived_q;

	// Integrator of the axis at work stays within its clamp.
	logic integ_in_range;
	assign integ_in_range = (integ_q[cmd.axis] <= tpvi_pkg::I_LIMIT) &&
		(integ_q[cmd.axis] >= -tpvi_pkg::I_LIMIT);

	`ASSERT_ALWAYS(a_integ_clamp, clk, arst_n, integ_in_range)

endmodule

`default_nettype wire

FILE: rtl/three_axis_pid_variable_integral.sv
// Three-axis PID position controller with a variable-speed integral weight.
// Each tick runs through the axes in turn; an axis whose error lies in the fade band
// also waits for the 48-step divider to compute its integral weight.
// Ticks are taken one at a time; a finished result waits in an output register while
// the next tick is taken, and is replaced only once the consumer has taken it.
// Reset (arst_n low) restores the config registers and clears control and PID history.
`default_nettype none

module three_axis_pid_variable_integral #(
	parameter int LOOP_RATE_HZ = 50
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               restart,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic signed [31:0] target_z,
	input  wire logic signed [31:0] measured_x,
	input  wire logic signed [31:0] measured_y,
	input  wire logic signed [31:0] measured_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [16:0]      vel_x,
	output logic signed [16:0]      vel_y,
	output logic signed [16:0]      vel_z,
	output logic                    arrived
);

	tpvi_pkg::cmd_t    cmd;
	tpvi_pkg::status_t status;

	tpvi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tpvi_datapath #(
		.LOOP_RATE_HZ (LOOP_RATE_HZ)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.restart    (restart),
		.target_x   (target_x),
		.target_y   (target_y),
		.target_z   (target_z),
		.measured_x (measured_x),
		.measured_y (measured_y),
		.measured_z (measured_z),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_z      (vel_z),
		.arrived    (arrived)
	);

endmodule

`default_nettype wire
